// File: src/multichannel_sample_packetizer_macros.svh
// ----------------------------------------------------------------------------
// Sample packetizer assertion macros
// Shared concurrent assertion forms for the packetizer checkers.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SAMPLE_PACKETIZER_MACROS_SVH
`define MULTICHANNEL_SAMPLE_PACKETIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/msp_pkg.sv
// ----------------------------------------------------------------------------
// Sample packetizer package
// Constants, action codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int BUF_BYTES   = 1024;
    localparam int NUM_SLOTS   = 4;
    localparam int CYCLE_TICKS = 20;

    // field widths
    localparam int ACT_W    = 2;
    localparam int SAMP_W   = 16;
    localparam int NUM_CH   = 8;
    localparam int SLOT_W   = 2;
    localparam int OFF_W    = 10;
    localparam int BYTE_W   = 8;

    // internal widths
    localparam int WI_W     = $clog2(BUF_BYTES + 2 * NUM_CH + 1);
    localparam int TIC_W    = $clog2(CYCLE_TICKS);
    localparam int PEND_W   = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W    = 16;
    localparam int NB_W     = 5;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam int FULL_SCAN_BYTES = 2 * NUM_CH;
    localparam int PAIR_BYTES      = 4;
    localparam int HDR_BYTES       = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CONSUME = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    // one item's worth of byte writes
    typedef struct packed {
        logic [NB_W-1:0]              samp_bytes;
        logic [WI_W-1:0]              wi;
        logic [SLOT_W-1:0]            slot;
        logic                         has_hdr;
        logic [SLOT_W-1:0]            hslot;
        logic [BYTE_W-1:0]            cnt;
        logic                         status;
        logic                         done;
        logic                         overrun;
        logic                         trigger;
        logic [NUM_CH-1:0][SAMP_W-1:0] samp;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: src/msp_queue.sv
// ----------------------------------------------------------------------------
// Sample packetizer job queue
// Two-entry queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module msp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  msp_pkg::job_t  push_job,
    input  logic           pop,
    output msp_pkg::job_t  head_job,
    output msp_pkg::q_status_t status
);
    import msp_pkg::*;

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    // store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/msp_front.sv
// ----------------------------------------------------------------------------
// Sample packetizer front end
// Accepts items, keeps the buffer bookkeeping and issues byte-write jobs.
// ----------------------------------------------------------------------------
module msp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [msp_pkg::ACT_W-1:0]     action,
    input  logic [msp_pkg::NUM_CH-1:0][msp_pkg::SAMP_W-1:0] samples,
    input  msp_pkg::q_status_t            q_status,
    output logic                          push,
    output msp_pkg::job_t                 push_job
);
    import msp_pkg::*;

    logic [WI_W-1:0]   wi_reg,   wi_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [TIC_W-1:0]  tic_reg,  tic_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              trig_reg, trig_next;

    logic              accept;
    logic [NB_W-1:0]   nsb;
    logic [WI_W-1:0]   wi_end;
    logic [TIC_W-1:0]  tic_inc;
    logic [SLOT_W-1:0] slot_inc;
    logic [PEND_W-1:0] pend_inc;
    logic              full;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // tick arithmetic
    always_comb
    begin
        nsb      = (tic_reg == '0) ? NB_W'(FULL_SCAN_BYTES) : NB_W'(PAIR_BYTES);
        wi_end   = wi_reg + WI_W'(nsb);
        full     = (wi_end >= WI_W'(BUF_BYTES));
        tic_inc  = (tic_reg == TIC_W'(CYCLE_TICKS - 1)) ? '0 : tic_reg + 1'b1;
        slot_inc = (slot_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
        pend_inc = (pend_reg == PEND_W'(NUM_SLOTS)) ? pend_reg : pend_reg + 1'b1;
    end

    // decode the action and build the job
    always_comb
    begin
        wi_next   = wi_reg;
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        tic_next  = tic_reg;
        pend_next = pend_reg;
        trig_next = trig_reg;
        push      = 1'b0;

        push_job            = '0;
        push_job.samp       = samples;
        push_job.wi         = wi_reg;
        push_job.slot       = slot_reg;

        unique case (action)
            ACT_TICK:
            begin
                push                = accept;
                push_job.samp_bytes = nsb;
                push_job.has_hdr    = full;
                push_job.hslot      = slot_inc;
                push_job.cnt        = cnt_reg[BYTE_W-1:0];
                push_job.status     = (tic_inc != '0);
                push_job.done       = 1'b1;
                if (full)
                begin
                    tic_next  = '0;
                    slot_next = slot_inc;
                    cnt_next  = cnt_reg + 1'b1;
                    wi_next   = WI_W'(HDR_BYTES);
                    pend_next = pend_inc;
                    trig_next = 1'b1;
                    push_job.overrun = (pend_inc == PEND_W'(NUM_SLOTS));
                    push_job.trigger = 1'b1;
                end
                else
                begin
                    tic_next = tic_inc;
                    wi_next  = wi_end;
                    push_job.overrun = (pend_reg == PEND_W'(NUM_SLOTS));
                    push_job.trigger = trig_reg;
                end
            end
            ACT_RESTART:
            begin
                push      = accept;
                push_job.has_hdr = 1'b1;
                slot_next = '0;
                cnt_next  = CNT_W'(1);
                tic_next  = '0;
                pend_next = '0;
                trig_next = 1'b0;
                wi_next   = WI_W'(HDR_BYTES);
            end
            ACT_CONSUME:
            begin
                pend_next = (pend_reg == '0) ? '0 : pend_reg - 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // update bookkeeping on accepted items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= WI_W'(HDR_BYTES);
            slot_reg <= '0;
            cnt_reg  <= CNT_W'(1);
            tic_reg  <= '0;
            pend_reg <= '0;
            trig_reg <= 1'b0;
        end
        else if (accept)
        begin
            wi_reg   <= wi_next;
            slot_reg <= slot_next;
            cnt_reg  <= cnt_next;
            tic_reg  <= tic_next;
            pend_reg <= pend_next;
            trig_reg <= trig_next;
        end
    end

endmodule

// File: src/msp_back.sv
// ----------------------------------------------------------------------------
// Sample packetizer back end
// Walks one job a byte per cycle unless the output stalls, and drives the registered output item.
// ----------------------------------------------------------------------------
module msp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msp_pkg::job_t               head_job,
    input  msp_pkg::q_status_t          q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [msp_pkg::SLOT_W-1:0]  slot,
    output logic [msp_pkg::OFF_W-1:0]   byte_offset,
    output logic [msp_pkg::BYTE_W-1:0]  byte_value,
    output logic                        buffer_done,
    output logic                        overrun,
    output logic                        trigger,
    output logic                        last
);
    import msp_pkg::*;

    job_t              job_reg;
    logic              busy_reg;
    logic [NB_W-1:0]   j_reg;
    logic              valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [BYTE_W-1:0] val_reg;
    logic              done_reg;
    logic              ovr_reg;
    logic              trig_reg;
    logic              last_reg;

    logic              out_free;
    logic              step;
    logic              fin;
    logic [NB_W-1:0]   nbytes;
    logic              in_samp;
    logic [WI_W-1:0]   off;
    logic              keep;
    logic              hb;
    logic [SAMP_W-1:0] cur_samp;
    logic [SLOT_W-1:0] slot_next;
    logic [OFF_W-1:0]  off_next;
    logic [BYTE_W-1:0] val_next;
    logic              done_next;

    assign out_free = !valid_reg || out_ready;
    assign step     = busy_reg && out_free;
    assign nbytes   = job_reg.samp_bytes + (job_reg.has_hdr ? NB_W'(HDR_BYTES) : '0);
    assign fin      = step && (j_reg == nbytes - 1'b1);
    assign pop      = !q_status.empty && (!busy_reg || fin);

    // select the byte for the current step
    always_comb
    begin
        in_samp  = (j_reg < job_reg.samp_bytes);
        off      = job_reg.wi + WI_W'(j_reg);
        keep     = !in_samp || (off < WI_W'(BUF_BYTES));
        hb       = j_reg[0] ^ job_reg.samp_bytes[0];
        cur_samp = job_reg.samp[j_reg[3:1]];
        if (in_samp)
        begin
            slot_next = job_reg.slot;
            off_next  = off[OFF_W-1:0];
            val_next  = j_reg[0] ? cur_samp[BYTE_W-1:0] : cur_samp[SAMP_W-1:BYTE_W];
            done_next = 1'b0;
        end
        else
        begin
            slot_next = job_reg.hslot;
            off_next  = OFF_W'(hb);
            val_next  = hb ? BYTE_W'(job_reg.status) : job_reg.cnt;
            done_next = job_reg.done;
        end
    end

    // hold the job being walked
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
    end

    // advance the byte walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            j_reg    <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            j_reg    <= '0;
        end
        else if (fin)
        begin
            busy_reg <= 1'b0;
        end
        else if (step)
        begin
            j_reg <= j_reg + 1'b1;
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= step && keep;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (step && keep)
        begin
            slot_reg <= slot_next;
            off_reg  <= off_next;
            val_reg  <= val_next;
            done_reg <= done_next;
            ovr_reg  <= job_reg.overrun;
            trig_reg <= job_reg.trigger;
            last_reg <= (j_reg == nbytes - 1'b1);
        end
    end

    assign out_valid   = valid_reg;
    assign slot        = slot_reg;
    assign byte_offset = off_reg;
    assign byte_value  = val_reg;
    assign buffer_done = done_reg;
    assign overrun     = ovr_reg;
    assign trigger     = trig_reg;
    assign last        = last_reg;

endmodule

// File: src/multichannel_sample_packetizer.sv
// ----------------------------------------------------------------------------
// Multichannel sample packetizer
// Packs converter samples and buffer headers into a ring of byte buffers.
// ----------------------------------------------------------------------------
// Input stream (s_*): one item per sampling tick, consume or restart, kind
// in s_tuser, the eight 16-bit channel samples in s_tdata.
// Output stream (m_*): one item per byte written into a slot, with slot,
// offset, value and the overrun and trigger flags in m_tdata, buffer_done in
// m_tuser and m_tlast on the final byte caused by an input item.
// A tick gives 4 sample bytes, 16 on a full-scan tick, and 2 header bytes
// more when the buffer fills; a restart gives 2 header bytes; a consume
// gives none, so an item has up to 18 bytes. The back end emits one byte
// per cycle while m_tready is high. A two-entry job queue lets the front
// accept the next items while the back end is still writing.
// Reset puts write position 2, slot 0, counter 1 and no pending buffers.
// When m_tready is low the current byte holds; the queue fills and then
// s_tready drops until the back end moves again.
// ----------------------------------------------------------------------------
module multichannel_sample_packetizer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sample_ch0 .. sample_ch7, 16 bits each, ch0 lowest
    input  logic [127:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[1:0], byte_offset[11:2], byte_value[19:12], overrun[20],
    // trigger[21], zero pad[23:22]
    output logic [23:0]  m_tdata,
    // buffer_done
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);
    import msp_pkg::*;

    logic                          push;
    job_t                          push_job;
    job_t                          head_job;
    q_status_t                     q_status;
    logic                          pop;
    logic [NUM_CH-1:0][SAMP_W-1:0] samples;
    logic [SLOT_W-1:0]             slot;
    logic [OFF_W-1:0]              byte_offset;
    logic [BYTE_W-1:0]             byte_value;
    logic                          buffer_done;
    logic                          overrun;
    logic                          trigger;

    assign samples = s_tdata;

    msp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .action   (s_tuser),
        .samples  (samples),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    msp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    msp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .slot        (slot),
        .byte_offset (byte_offset),
        .byte_value  (byte_value),
        .buffer_done (buffer_done),
        .overrun     (overrun),
        .trigger     (trigger),
        .last        (m_tlast)
    );

    // pack the output item
    assign m_tdata = {2'b00, trigger, overrun, byte_value, byte_offset, slot};
    assign m_tuser = buffer_done;

endmodule

// File: src/msp_checker.sv
// ----------------------------------------------------------------------------
// Sample packetizer port checker
// Watches the top-level ports for handshake and packing slips.
// ----------------------------------------------------------------------------
`include "multichannel_sample_packetizer_macros.svh"

module msp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast
);

    // a stalled output item stays offered
    `MSP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
        "output item dropped while stalled")

    // the input side cannot close without an accepted item
    `MSP_ASSERT_NEXT(a_in_ready_hold, clk, rst_n, s_tready && !s_tvalid, s_tready,
        "s_tready dropped with no item accepted")

    // buffer_done marks only header bytes
    `MSP_ASSERT_IMPLY(a_done_hdr, clk, rst_n, m_tvalid && m_tuser[0],
        m_tdata[11:2] <= 10'd1, "buffer_done on a non-header byte")

    // the counter byte of a header never closes an item
    `MSP_ASSERT_IMPLY(a_hdr0_not_last, clk, rst_n, m_tvalid && (m_tdata[11:2] == 10'd0),
        !m_tlast, "header counter byte marked last")

    // the pad bits stay zero
    `MSP_ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[23:22] == 2'b00,
        "nonzero pad bits in output item")

endmodule

bind multichannel_sample_packetizer msp_checker u_msp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
